// File: rtl/rme_pkg.sv
// Package for the rotation matrix to Euler angle block.
// Holds shared widths, the arctangent table, the square-root step and the sideband types.
package rme_pkg;

	localparam int XW        = 34;   // CORDIC x/y datapath, operands scaled by 2^14
	localparam int ZW        = 36;   // angle accumulator, 2^-30 rad units
	localparam int OPW       = 17;   // atan2 operand width
	localparam int SQW       = 30;   // square-root work width
	localparam int LANES     = 3;    // pitch, roll, yaw
	localparam int TABLE_LEN = 24;
	localparam int ONE_Q14   = 16384;
	localparam int LOCK_MAX  = 81;   // c <= 81.92 counts means gimbal lock
	localparam int SQ_ITERS     = 15;
	localparam int SQ_PER_STAGE = 3;
	localparam int SQ_STAGES    = SQ_ITERS / SQ_PER_STAGE;

	localparam int LANE_PITCH = 0;
	localparam int LANE_ROLL  = 1;
	localparam int LANE_YAW   = 2;

	localparam logic signed [ZW-1:0] PI_ACC = ZW'(64'sd3373259426);

	typedef logic signed [OPW-1:0] op_t;
	typedef logic signed [ZW-1:0]  ang_t;

	typedef struct packed {
		logic [SQW-1:0] n;
		logic [SQW-1:0] root;
	} sq_st_t;

	// sideband carried through the square-root pipe
	typedef struct packed {
		logic               pos_c;
		logic signed [15:0] s;
		logic signed [15:0] e0;
		logic signed [15:0] e1;
		logic signed [15:0] e4;
		logic signed [15:0] e5;
		logic signed [15:0] e9;
		logic signed [15:0] e10;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
	} sq_tag_t;

	// sideband carried through the CORDIC pipe
	typedef struct packed {
		logic               pos_c;
		logic               lock;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
	} cr_tag_t;

	function automatic ang_t atan_entry(input int unsigned i);
		ang_t r;
		case (i)
			0:  r = ZW'(843314856);
			1:  r = ZW'(497837829);
			2:  r = ZW'(263043836);
			3:  r = ZW'(133525158);
			4:  r = ZW'(67021686);
			5:  r = ZW'(33543515);
			6:  r = ZW'(16775850);
			7:  r = ZW'(8388437);
			8:  r = ZW'(4194282);
			9:  r = ZW'(2097149);
			10: r = ZW'(1048575);
			11: r = ZW'(524287);
			12: r = ZW'(262143);
			13: r = ZW'(131071);
			14: r = ZW'(65535);
			15: r = ZW'(32767);
			16: r = ZW'(16383);
			17: r = ZW'(8191);
			18: r = ZW'(4095);
			19: r = ZW'(2047);
			20: r = ZW'(1023);
			21: r = ZW'(511);
			22: r = ZW'(255);
			23: r = ZW'(127);
			default: r = '0;
		endcase
		return r;
	endfunction

	// one digit of the restoring square root; step k tests bit 2^(28-2k)
	function automatic sq_st_t sqrt_iter(input sq_st_t a, input int unsigned k);
		sq_st_t         r;
		logic [SQW-1:0] b;
		logic [SQW-1:0] t;
		b = SQW'(1) << (28 - 2 * k);
		t = a.root + b;
		if (a.n >= t) begin
			r.n    = a.n - t;
			r.root = (a.root >> 1) + b;
		end else begin
			r.n    = a.n;
			r.root = a.root >> 1;
		end
		return r;
	endfunction

endpackage

// File: rtl/rme_in_if.sv
// Input channel of the Euler block: pose matrix entries and translation.
// Standalone interface, no dependencies.
interface rme_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] elem0;
	logic signed [15:0] elem1;
	logic signed [15:0] elem4;
	logic signed [15:0] elem5;
	logic signed [15:0] elem8;
	logic signed [15:0] elem9;
	logic signed [15:0] elem10;
	logic signed [31:0] trans_x;
	logic signed [31:0] trans_y;
	logic signed [31:0] trans_z;

	modport source(output valid, elem0, elem1, elem4, elem5, elem8, elem9, elem10,
		trans_x, trans_y, trans_z, input ready);
	modport sink(input valid, elem0, elem1, elem4, elem5, elem8, elem9, elem10,
		trans_x, trans_y, trans_z, output ready);
endinterface

// File: rtl/rme_out_if.sv
// Output channel of the Euler block: angles, translation and lock flag.
// Standalone interface, no dependencies.
interface rme_out_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [14:0] yaw_angle;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic               gimbal_lock;

	modport source(output valid, roll_angle, pitch_angle, yaw_angle, pos_x, pos_y, pos_z,
		gimbal_lock, input ready);
	modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pos_x, pos_y, pos_z,
		gimbal_lock, output ready);
endinterface

// File: rtl/rme_isqrt.sv
// Pipelined integer square root of 2^28 - s^2, three digits per stage.
// Depends on rme_pkg.
module rme_isqrt import rme_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_vld,
	input  logic [28:0]    sq,
	input  sq_tag_t        in_tag,
	output logic           out_vld,
	output logic [14:0]    root,
	output sq_tag_t        out_tag
);

	sq_st_t  st_s  [SQ_STAGES];
	sq_tag_t tag_s [SQ_STAGES];
	logic    vld_s [SQ_STAGES];

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_st
		sq_st_t  st_in;
		sq_st_t  st_nx;
		sq_tag_t tag_in;
		logic    vld_in;

		if (g == 0) begin : g_first
			assign st_in.n    = (SQW'(1) << 28) - SQW'(sq);
			assign st_in.root = '0;
			assign tag_in     = in_tag;
			assign vld_in     = in_vld;
		end else begin : g_rest
			assign st_in  = st_s[g-1];
			assign tag_in = tag_s[g-1];
			assign vld_in = vld_s[g-1];
		end

		always_comb begin
			st_nx = st_in;
			for (int j = 0; j < SQ_PER_STAGE; j++)
				st_nx = sqrt_iter(st_nx, g * SQ_PER_STAGE + j);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (adv) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[g]  <= st_nx;
				tag_s[g] <= tag_in;
			end
		end
	end

	assign out_vld = vld_s[SQ_STAGES-1];
	assign root    = st_s[SQ_STAGES-1].root[14:0];
	assign out_tag = tag_s[SQ_STAGES-1];

endmodule

// File: rtl/rme_cordic.sv
// Unrolled vectoring CORDIC, three atan2 lanes side by side, one stage per iteration.
// Depends on rme_pkg.
module rme_cordic import rme_pkg::*; #(
	parameter int STAGES = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  logic    in_vld,
	input  op_t     y_in [LANES],
	input  op_t     x_in [LANES],
	input  cr_tag_t in_tag,
	output logic    out_vld,
	output ang_t    z_out [LANES],
	output cr_tag_t out_tag
);

	// stage 0 is the half-plane fold, stages 1..STAGES the micro-rotations
	logic signed [XW-1:0] x_s [STAGES+1][LANES];
	logic signed [XW-1:0] y_s [STAGES+1][LANES];
	ang_t                 z_s [STAGES+1][LANES];
	logic                 zr_s [STAGES+1][LANES];
	cr_tag_t              tag_s [STAGES+1];
	logic                 vld_s [STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STAGES; i++)
				vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
			for (int i = 1; i <= STAGES; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[0] <= in_tag;
			for (int i = 1; i <= STAGES; i++)
				tag_s[i] <= tag_s[i-1];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		op_t xf;
		op_t yf;
		logic neg;

		assign neg = x_in[l] < 0;
		assign xf  = neg ? -x_in[l] : x_in[l];
		assign yf  = neg ? -y_in[l] : y_in[l];

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[0][l]  <= XW'(xf) <<< 14;
				y_s[0][l]  <= XW'(yf) <<< 14;
				zr_s[0][l] <= (x_in[l] == '0) && (y_in[l] == '0);
				if (!neg)
					z_s[0][l] <= '0;
				else if (y_in[l] >= 0)
					z_s[0][l] <= PI_ACC;
				else
					z_s[0][l] <= -PI_ACC;
			end
		end

		for (genvar i = 1; i <= STAGES; i++) begin : g_it
			logic signed [XW-1:0] xs;
			logic signed [XW-1:0] ys;

			assign xs = x_s[i-1][l] >>> (i - 1);
			assign ys = y_s[i-1][l] >>> (i - 1);

			always_ff @(posedge clk) begin
				if (adv) begin
					zr_s[i][l] <= zr_s[i-1][l];
					if (y_s[i-1][l] >= 0) begin
						x_s[i][l] <= x_s[i-1][l] + ys;
						y_s[i][l] <= y_s[i-1][l] - xs;
						z_s[i][l] <= z_s[i-1][l] + atan_entry(i - 1);
					end else begin
						x_s[i][l] <= x_s[i-1][l] - ys;
						y_s[i][l] <= y_s[i-1][l] + xs;
						z_s[i][l] <= z_s[i-1][l] - atan_entry(i - 1);
					end
				end
			end
		end

		assign z_out[l] = zr_s[STAGES][l] ? '0 : z_s[STAGES][l];
	end

	assign out_vld = vld_s[STAGES];
	assign out_tag = tag_s[STAGES];

endmodule

// File: rtl/rotation_matrix_to_euler.sv
// Channel | Dir | Beat contents
// pose    | in  | elem0..elem10 (Q1.14), trans_x/y/z
// euler   | out | roll/pitch/yaw angles, pos_x/y/z, gimbal_lock
// Registered stages in order: input square, five square-root stages,
// the CORDIC fold plus CORDIC_STAGES rotations, and the rounding/output register.
// One beat per cycle is sustained unless stalled; the whole pipe advances together.
// Reset clears only the valid bits. When the output beat is stalled, every stage
// holds and pose.ready drops in the same cycle.
// Depends on rme_pkg, rme_in_if, rme_out_if, rme_isqrt, rme_cordic.
module rotation_matrix_to_euler import rme_pkg::*; #(
	parameter int CORDIC_STAGES   = 16,
	parameter int ANGLE_FRAC_BITS = 12
) (
	input  logic    clk,
	input  logic    arst_n,
	rme_in_if.sink  pose,
	rme_out_if.source euler
);

	localparam int ACC_SHIFT = 30 - ANGLE_FRAC_BITS;
	localparam ang_t HALF    = ang_t'(1) <<< (ACC_SHIFT - 1);

	logic adv;
	logic vld_o_q;

	assign adv        = !vld_o_q || euler.ready;
	assign pose.ready = adv;

	// stage 1: clamp sin(pitch) and square it
	logic signed [15:0] s_c;
	logic [28:0]        sq_s1;
	sq_tag_t            tag_s1;
	logic               vld_s1;
	logic signed [31:0] sq_full;

	always_comb begin
		if (pose.elem8 > 16'sd16384)
			s_c = 16'sd16384;
		else if (pose.elem8 < -16'sd16384)
			s_c = -16'sd16384;
		else
			s_c = pose.elem8;
	end
	assign sq_full = s_c * s_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pose.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1        <= sq_full[28:0];
			tag_s1.pos_c <= pose.elem0 > 0;
			tag_s1.s     <= s_c;
			tag_s1.e0    <= pose.elem0;
			tag_s1.e1    <= pose.elem1;
			tag_s1.e4    <= pose.elem4;
			tag_s1.e5    <= pose.elem5;
			tag_s1.e9    <= pose.elem9;
			tag_s1.e10   <= pose.elem10;
			tag_s1.tx    <= pose.trans_x;
			tag_s1.ty    <= pose.trans_y;
			tag_s1.tz    <= pose.trans_z;
		end
	end

	logic        sq_vld;
	logic [14:0] c_root;
	sq_tag_t     sq_tag;

	rme_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s1),
		.sq      (sq_s1),
		.in_tag  (tag_s1),
		.out_vld (sq_vld),
		.root    (c_root),
		.out_tag (sq_tag)
	);

	// operand selection for the three arctangents
	logic    lock;
	op_t     cy [LANES];
	op_t     cx [LANES];
	cr_tag_t cr_in;

	assign lock = c_root <= 15'(LOCK_MAX);

	always_comb begin
		cy[LANE_PITCH] = OPW'(sq_tag.s);
		cx[LANE_PITCH] = OPW'(c_root);
		if (lock) begin
			cy[LANE_ROLL] = '0;
			cx[LANE_ROLL] = '0;
			cy[LANE_YAW]  = OPW'(sq_tag.e1);
			cx[LANE_YAW]  = OPW'(sq_tag.e5);
		end else if (sq_tag.pos_c) begin
			cy[LANE_ROLL] = -OPW'(sq_tag.e9);
			cx[LANE_ROLL] = OPW'(sq_tag.e10);
			cy[LANE_YAW]  = -OPW'(sq_tag.e4);
			cx[LANE_YAW]  = OPW'(sq_tag.e0);
		end else begin
			cy[LANE_ROLL] = OPW'(sq_tag.e9);
			cx[LANE_ROLL] = -OPW'(sq_tag.e10);
			cy[LANE_YAW]  = OPW'(sq_tag.e4);
			cx[LANE_YAW]  = -OPW'(sq_tag.e0);
		end
		cr_in.pos_c = sq_tag.pos_c;
		cr_in.lock  = lock;
		cr_in.tx    = sq_tag.tx;
		cr_in.ty    = sq_tag.ty;
		cr_in.tz    = sq_tag.tz;
	end

	logic    cr_vld;
	ang_t    z_res [LANES];
	cr_tag_t cr_tag;

	rme_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (sq_vld),
		.y_in    (cy),
		.x_in    (cx),
		.in_tag  (cr_in),
		.out_vld (cr_vld),
		.z_out   (z_res),
		.out_tag (cr_tag)
	);

	// pitch fold for non-positive elem0, then round half up
	ang_t pz;
	ang_t r_roll;
	ang_t r_pitch;
	ang_t r_yaw;

	assign pz      = cr_tag.pos_c ? z_res[LANE_PITCH] : PI_ACC - z_res[LANE_PITCH];
	assign r_roll  = (z_res[LANE_ROLL] + HALF) >>> ACC_SHIFT;
	assign r_pitch = (pz + HALF) >>> ACC_SHIFT;
	assign r_yaw   = (z_res[LANE_YAW] + HALF) >>> ACC_SHIFT;

	logic signed [14:0] roll_q;
	logic signed [15:0] pitch_q;
	logic signed [14:0] yaw_q;
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	logic signed [31:0] pzp_q;
	logic               lock_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_q <= 1'b0;
		end else if (adv) begin
			vld_o_q <= cr_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			roll_q  <= r_roll[14:0];
			pitch_q <= r_pitch[15:0];
			yaw_q   <= r_yaw[14:0];
			px_q    <= cr_tag.tx;
			py_q    <= cr_tag.ty;
			pzp_q   <= cr_tag.tz;
			lock_q  <= cr_tag.lock;
		end
	end

	assign euler.valid       = vld_o_q;
	assign euler.roll_angle  = roll_q;
	assign euler.pitch_angle = pitch_q;
	assign euler.yaw_angle   = yaw_q;
	assign euler.pos_x       = px_q;
	assign euler.pos_y       = py_q;
	assign euler.pos_z       = pzp_q;
	assign euler.gimbal_lock = lock_q;

`ifndef SYNTHESIS
	// roll is forced to zero whenever the lock flag is raised
	a_lock_roll: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid && euler.gimbal_lock |-> euler.roll_angle == '0)
		else $error("roll not zero under gimbal lock");

	// a stalled output freezes the pipe, so input must not be taken
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid && !euler.ready |-> !pose.ready)
		else $error("input accepted during output stall");

	// a stalled beat must still be there next cycle
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid && !euler.ready |=> euler.valid && $stable(euler.yaw_angle))
		else $error("stalled result lost");
`endif

endmodule

// File: test/rme_tb_if.sv
`timescale 1ns / 1ps
// Testbench beat types for the pose and Euler channels.
// Standalone package, no dependencies.
package rme_tb_types;
	typedef struct {
		logic signed [15:0] e0, e1, e4, e5, e8, e9, e10;
		logic signed [31:0] tx, ty, tz;
	} pose_t;

	typedef struct {
		logic signed [14:0] roll;
		logic signed [15:0] pitch;
		logic signed [14:0] yaw;
		logic signed [31:0] px, py, pz;
		logic               lock;
	} euler_t;
endpackage

// File: test/rotation_matrix_to_euler_tb.sv
`timescale 1ns / 1ps
// Testbench for rotation_matrix_to_euler: random and directed pose beats, a local
// CORDIC/isqrt predictor, and a scoreboard on the Euler channel.
// Depends on rme_pkg, rme_in_if, rme_out_if, rme_tb_types and the RTL.
module rotation_matrix_to_euler_tb;
	import rme_tb_types::*;

	localparam int STAGES = 16;
	localparam int FRAC   = 12;
	localparam int LAT    = STAGES + 8;
	localparam longint PI_Z = 64'sd3373259426;

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	rme_in_if  pose();
	rme_out_if euler();

	rotation_matrix_to_euler #(.CORDIC_STAGES(STAGES), .ANGLE_FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .pose(pose.sink), .euler(euler.source));

	pose_t  pending_poses[$];
	euler_t expected_angles[$];
	int     mismatches = 0;
	bit     hold_sink = 0;
	bit     pause_source = 0;

	longint atan_z[24] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
		16383, 8191, 4095, 2047, 1023, 511, 255, 127};

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_Z : -PI_Z;
			x = -x;
			y = -y;
		end
		x = x * 16384;
		y = y * 16384;
		for (int i = 0; i < STAGES && i < 24; i++) begin
			xs = fshift(x, i);
			ys = fshift(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_z[i];
			end else begin
				x -= ys; y += xs; z -= atan_z[i];
			end
		end
		return z;
	endfunction

	function automatic longint int_sqrt(longint n);
		longint root, b;
		root = 0;
		b = 64'd1 << 30;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic longint round_angle(longint a);
		return fshift(a + (64'sd1 << (30 - FRAC - 1)), 30 - FRAC);
	endfunction

	function automatic euler_t predict_euler(pose_t p);
		euler_t r;
		longint s, c, pitch, roll, yaw;
		bit pos_c, lock;
		pos_c = p.e0 > 0;
		s = p.e8;
		if (s > 16384) s = 16384;
		if (s < -16384) s = -16384;
		c = int_sqrt(64'sd268435456 - s * s);
		pitch = vector_angle(s, c);
		if (!pos_c) pitch = PI_Z - pitch;
		lock = c * 1000 <= 81920;
		if (!lock) begin
			if (pos_c) begin
				roll = vector_angle(-longint'(p.e9), p.e10);
				yaw  = vector_angle(-longint'(p.e4), p.e0);
			end else begin
				roll = vector_angle(p.e9, -longint'(p.e10));
				yaw  = vector_angle(p.e4, -longint'(p.e0));
			end
		end else begin
			roll = 0;
			yaw  = vector_angle(p.e1, p.e5);
		end
		r.roll  = 15'(round_angle(roll));
		r.pitch = 16'(round_angle(pitch));
		r.yaw   = 15'(round_angle(yaw));
		r.px = p.tx; r.py = p.ty; r.pz = p.tz;
		r.lock = lock;
		return r;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic signed [15:0] rand_elem();
		int k;
		k = $urandom_range(0, 9);
		if (k < 7) return 16'($signed($urandom_range(0, 32768)) - 16384);
		if (k < 8) return 16'($urandom);
		return (k == 8) ? 16'sd16384 : -16'sd16384;
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		p.e0 = rand_elem(); p.e1 = rand_elem(); p.e4 = rand_elem(); p.e5 = rand_elem();
		p.e8 = rand_elem(); p.e9 = rand_elem(); p.e10 = rand_elem();
		// steer some beats into and around the gimbal-lock band or onto the elem0 sign boundary
		case ($urandom_range(0, 5))
			0: p.e8 = 16'($signed($urandom_range(16370, 16384)));
			1: p.e8 = -16'($signed($urandom_range(16370, 16384)));
			2: p.e0 = $urandom_range(0, 1) ? 16'sd0 : 16'($signed($urandom_range(0, 3)) - 1);
			default: ;
		endcase
		p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
		return p;
	endfunction

	function automatic pose_t make_pose(int a0, a1, a4, a5, a8, a9, a10);
		pose_t p;
		p.e0 = 16'(a0); p.e1 = 16'(a1); p.e4 = 16'(a4); p.e5 = 16'(a5);
		p.e8 = 16'(a8); p.e9 = 16'(a9); p.e10 = 16'(a10);
		p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
		return p;
	endfunction

	// driver; acceptance is latched at the rising edge where it happens
	int    src_gap = 0;
	bit    src_took = 0;
	pose_t cur_pose;
	always @(posedge clk) src_took <= pose.valid && pose.ready;
	always @(negedge clk) begin
		if (arst_n) begin
			if (src_took) begin
				expected_angles = {expected_angles, predict_euler(cur_pose)};
				src_gap = gap_len();
			end
			if (!pose.valid || src_took) begin
				if (src_gap > 0 || pause_source || pending_poses.size() == 0) begin
					if (src_gap > 0) src_gap--;
					pose.valid <= 0;
				end else begin
					cur_pose = pending_poses.pop_front();
					pose.valid   <= 1;
					pose.elem0   <= cur_pose.e0;  pose.elem1  <= cur_pose.e1;
					pose.elem4   <= cur_pose.e4;  pose.elem5  <= cur_pose.e5;
					pose.elem8   <= cur_pose.e8;  pose.elem9  <= cur_pose.e9;
					pose.elem10  <= cur_pose.e10;
					pose.trans_x <= cur_pose.tx;  pose.trans_y <= cur_pose.ty;
					pose.trans_z <= cur_pose.tz;
				end
			end
		end
	end

	// sink: random backpressure, plus one long hold
	int snk_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_sink) begin
				euler.ready <= 0;
			end else if (snk_gap > 0) begin
				snk_gap--;
				euler.ready <= 0;
			end else begin
				euler.ready <= 1;
				snk_gap = gap_len();
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		euler_t e;
		if (arst_n && euler.valid && euler.ready) begin
			if (expected_angles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected Euler beat at %0t", $time);
			end else begin
				e = expected_angles.pop_front();
				if (euler.roll_angle !== e.roll || euler.pitch_angle !== e.pitch ||
					euler.yaw_angle !== e.yaw || euler.pos_x !== e.px ||
					euler.pos_y !== e.py || euler.pos_z !== e.pz ||
					euler.gimbal_lock !== e.lock) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp r=%0d p=%0d y=%0d x=%h y=%h z=%h l=%b,",
							" got r=%0d p=%0d y=%0d x=%h y=%h z=%h l=%b"},
							e.roll, e.pitch, e.yaw, e.px, e.py, e.pz, e.lock,
							euler.roll_angle, euler.pitch_angle, euler.yaw_angle,
							euler.pos_x, euler.pos_y, euler.pos_z, euler.gimbal_lock);
				end
			end
		end
	end

	initial begin
		pose.valid = 0; euler.ready = 0;
		pose.elem0 = 0; pose.elem1 = 0; pose.elem4 = 0; pose.elem5 = 0;
		pose.elem8 = 0; pose.elem9 = 0; pose.elem10 = 0;
		pose.trans_x = 0; pose.trans_y = 0; pose.trans_z = 0;
		// identity, extremes, both atan operands zero, out-of-range sine, C < 0
		pending_poses = {pending_poses, make_pose(16384, 0, 0, 16384, 0, 0, 16384)};
		pending_poses = {pending_poses, make_pose(-16384, 0, 0, -16384, 0, 0, -16384)};
		pending_poses = {pending_poses, make_pose(0, 0, 0, 0, 0, 0, 0)};
		pending_poses = {pending_poses, make_pose(16384, 5, 7, 9, 16384, 3, 4)};
		pending_poses = {pending_poses, make_pose(-16384, 0, 0, 0, -16384, 0, 0)};
		pending_poses = {pending_poses, make_pose(100, -16384, 0, 16384, 32767, 0, 0)};
		pending_poses = {pending_poses,
			make_pose(-32768, 32767, -32768, 32767, -32768, 32767, -32768)};
		pending_poses = {pending_poses,
			make_pose(32767, -32768, 32767, -32768, 16383, -32768, 32767)};
		pending_poses = {pending_poses, make_pose(16384, 0, 0, 0, 16383, 0, 0)};
		pending_poses = {pending_poses, make_pose(-5, 0, 16384, 0, -16380, 16384, -16384)};
		pending_poses = {pending_poses, make_pose(3000, 0, -16384, 0, 1000, -16384, 0)};
		pending_poses = {pending_poses, make_pose(16384, 0, 0, 0, 0, 0, -1)};
		for (int i = 0; i < 400; i++) pending_poses = {pending_poses, rand_pose()};
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1;
		wait (pending_poses.size() == 0);
		// long receiver hold so the pipe fills and stalls the input
		hold_sink = 1;
		for (int i = 0; i < 150; i++) pending_poses = {pending_poses, rand_pose()};
		repeat (200) @(posedge clk);
		hold_sink = 0;
		wait (pending_poses.size() == 0);
		// sender pause until drained
		pause_source = 1;
		wait (expected_angles.size() == 0 && !pose.valid);
		pause_source = 0;
		for (int i = 0; i < 800; i++) pending_poses = {pending_poses, rand_pose()};
		wait (pending_poses.size() == 0);
		@(negedge clk);
		while (pose.valid) @(negedge clk);
		wait (expected_angles.size() == 0);
		repeat (LAT + 10) @(posedge clk);
		if (mismatches == 0 && expected_angles.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
